@@ rtl/core/hsd_pkg.sv @@
// Shared types and constants for the hall sequence detector.
// Used by hsd_count_ram, hall_sequence_detector_top and hsd_checker; no dependencies.
package hsd_pkg;

	// Field widths fixed by the interface.
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned STEP_W   = 3;
	localparam int unsigned MIN_W    = 16;
	localparam int unsigned ADDR_W   = CODE_W + STEP_W;
	localparam int unsigned NUM_ADDR = 1 << ADDR_W;

	// Default counter width.
	localparam int unsigned COUNT_WIDTH_DEF = 16;

	// Register reset value and special codes.
	localparam logic [MIN_W-1:0]  MIN_SAMPLES_RST = 16'd15;
	localparam logic [STEP_W-1:0] STEP_LIMIT      = 3'd6;
	localparam logic [STEP_W-1:0] LAST_STEP       = 3'd5;
	localparam logic [STEP_W-1:0] FIRST_STEP      = 3'd0;
	localparam logic [CODE_W-1:0] LAST_CODE       = 3'd7;
	localparam logic [CODE_W-1:0] FIRST_CODE      = 3'd0;
	localparam logic [3:0]        INVALID_WANTED  = 4'd2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// Control from the sequencer to the counter memory.
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              clear;
	} ram_ctrl_t;

endpackage

@@ rtl/core/hsd_count_ram.sv @@
// Counter memory of the hall sequence detector: one port for writes, one registered read port.
// Per-entry valid bits make cleared entries read as zero. Depends on hsd_pkg.
module hsd_count_ram #(
	parameter int unsigned COUNT_WIDTH = hsd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hsd_pkg::ram_ctrl_t     ctrl,
	input  logic [COUNT_WIDTH-1:0] wr_data,
	output logic [COUNT_WIDTH-1:0] rd_data
);

	logic [COUNT_WIDTH-1:0]       mem_q [hsd_pkg::NUM_ADDR];
	logic [hsd_pkg::NUM_ADDR-1:0] valid_q;
	logic [COUNT_WIDTH-1:0]       data_s1;
	logic                         hit_s1;

	// Storage array, no reset.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[ctrl.wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			data_s1 <= mem_q[ctrl.rd_addr];
		end
	end

	// Valid bits: reset and the clear command empty every entry at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				valid_q <= '0;
			end else if (ctrl.wr_en) begin
				valid_q[ctrl.wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				hit_s1 <= valid_q[ctrl.rd_addr];
			end
		end
	end

	// An entry never written since the last clear reads as zero.
	assign rd_data = hit_s1 ? data_s1 : '0;

endmodule

@@ rtl/core/hall_sequence_detector_top.sv @@
// Top level of the hall sequence detector: command sequencer, scan compare unit, result register.
// Depends on hsd_pkg and hsd_count_ram.
//
//  Channel   Handshake                           Payload
//  --------  ----------------------------------  ---------------------------------------
//  command   start, busy (accept: start && !busy)  cmd, sensor_code, drive_step
//  result    valid (no stall)                    hall_code, step_code, table_ok, last
//  config    min_samples_we                      min_samples
//
// A sample of steps zero to five is one memory read, then the saturating write-back.
// Clear, unused commands and samples of steps six or seven never raise busy.
// A read makes 48 counter reads through the single read port, one at a time
// into the shared compare unit, then gives 8 results.
// Reset clears the counters through their valid bits at once; no clearing pass is needed.
// The receiver cannot stall; the eight results come out in consecutive cycles.
module hall_sequence_detector_top #(
	parameter int unsigned COUNT_WIDTH = hsd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [hsd_pkg::CMD_W-1:0]    cmd,
	input  logic [hsd_pkg::CODE_W-1:0]   sensor_code,
	input  logic [hsd_pkg::STEP_W-1:0]   drive_step,
	input  logic                         min_samples_we,
	input  logic [hsd_pkg::MIN_W-1:0]    min_samples,
	output logic                         valid,
	output logic [hsd_pkg::CODE_W-1:0]   hall_code,
	output logic [hsd_pkg::STEP_W-1:0]   step_code,
	output logic                         table_ok,
	output logic                         last
);

	localparam int unsigned CMP_W = (COUNT_WIDTH > hsd_pkg::MIN_W) ? COUNT_WIDTH : hsd_pkg::MIN_W;

	hsd_pkg::state_t state_q, state_d;
	hsd_pkg::ram_ctrl_t ram_ctrl;

	logic [hsd_pkg::MIN_W-1:0]  min_samples_q;
	logic [hsd_pkg::ADDR_W-1:0] sample_addr_q;
	logic [hsd_pkg::ADDR_W-1:0] issue_ptr_q;
	logic                       issue_done_q;
	logic                       rd_valid_s1;
	logic [hsd_pkg::ADDR_W-1:0] addr_s1;
	logic [COUNT_WIDTH-1:0]     best_q;
	logic [hsd_pkg::STEP_W-1:0] pick_q;
	logic [hsd_pkg::STEP_W-1:0] picks_q [8];
	logic [3:0]                 invalid_q;
	logic [5:0]                 seen_q;
	logic [hsd_pkg::CODE_W-1:0] emit_idx_q;

	logic                       accept;
	logic                       scan_issue;
	logic                       emit_fire;
	logic                       scan_last;
	logic [COUNT_WIDTH-1:0]     rd_data;
	logic [COUNT_WIDTH-1:0]     wr_data;
	logic [hsd_pkg::STEP_W-1:0] step_s1;
	logic [hsd_pkg::CODE_W-1:0] code_s1;
	logic [COUNT_WIDTH-1:0]     best_base;
	logic [hsd_pkg::STEP_W-1:0] pick_base;
	logic [CMP_W-1:0]           count_ext;
	logic [CMP_W-1:0]           best_ext;
	logic [CMP_W-1:0]           min_ext;
	logic                       take;
	logic [COUNT_WIDTH-1:0]     best_next;
	logic [hsd_pkg::STEP_W-1:0] pick_next;
	logic [5:0]                 pick_onehot;

	assign accept = start && !busy;

	// Counter memory.
	hsd_count_ram #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_count_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ram_ctrl),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_samples_q <= hsd_pkg::MIN_SAMPLES_RST;
		end else if (min_samples_we) begin
			min_samples_q <= min_samples;
		end
	end

	// Address of the item in the compare stage.
	assign step_s1   = addr_s1[hsd_pkg::STEP_W-1:0];
	assign code_s1   = addr_s1[hsd_pkg::ADDR_W-1:hsd_pkg::STEP_W];
	assign scan_last = rd_valid_s1 && (step_s1 == hsd_pkg::LAST_STEP)
		&& (code_s1 == hsd_pkg::LAST_CODE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hsd_pkg::ST_IDLE: begin
				if (accept && (cmd == hsd_pkg::CMD_SAMPLE) && (drive_step < hsd_pkg::STEP_LIMIT)) begin
					state_d = hsd_pkg::ST_SAMPLE;
				end else if (accept && (cmd == hsd_pkg::CMD_READ)) begin
					state_d = hsd_pkg::ST_SCAN;
				end
			end
			hsd_pkg::ST_SAMPLE: begin
				state_d = hsd_pkg::ST_IDLE;
			end
			hsd_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = hsd_pkg::ST_EMIT;
				end
			end
			hsd_pkg::ST_EMIT: begin
				if (emit_idx_q == hsd_pkg::LAST_CODE) begin
					state_d = hsd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hsd_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs and memory control.
	always_comb begin
		busy             = 1'b1;
		scan_issue       = 1'b0;
		emit_fire        = 1'b0;
		ram_ctrl.rd_en   = 1'b0;
		ram_ctrl.rd_addr = {sensor_code, drive_step};
		ram_ctrl.wr_en   = 1'b0;
		ram_ctrl.wr_addr = sample_addr_q;
		ram_ctrl.clear   = 1'b0;
		unique case (state_q)
			hsd_pkg::ST_IDLE: begin
				busy           = 1'b0;
				ram_ctrl.rd_en = accept && (cmd == hsd_pkg::CMD_SAMPLE)
					&& (drive_step < hsd_pkg::STEP_LIMIT);
				ram_ctrl.clear = accept && (cmd == hsd_pkg::CMD_CLEAR);
			end
			hsd_pkg::ST_SAMPLE: begin
				ram_ctrl.wr_en = (rd_data != {COUNT_WIDTH{1'b1}});
			end
			hsd_pkg::ST_SCAN: begin
				scan_issue       = !issue_done_q;
				ram_ctrl.rd_en   = !issue_done_q;
				ram_ctrl.rd_addr = issue_ptr_q;
			end
			hsd_pkg::ST_EMIT: begin
				emit_fire = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Saturating increment for the sample write-back.
	assign wr_data = rd_data + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

	// Shared compare unit: running maximum per code, first step wins a tie.
	assign best_base = (step_s1 == hsd_pkg::FIRST_STEP) ? '0 : best_q;
	assign pick_base = (step_s1 == hsd_pkg::FIRST_STEP) ? '0 : pick_q;
	assign count_ext = CMP_W'(rd_data);
	assign best_ext  = CMP_W'(best_base);
	assign min_ext   = CMP_W'(min_samples_q);
	assign take      = (count_ext > best_ext);
	assign best_next = take ? rd_data : best_base;
	assign pick_next = (take && (count_ext > min_ext)) ? (step_s1 + 3'd1) : pick_base;

	// Step seen by the finished code, as one bit per step.
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			pick_onehot[i] = (pick_next == 3'(i + 1));
		end
	end

	// State register and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hsd_pkg::ST_IDLE;
			issue_ptr_q  <= '0;
			issue_done_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			emit_idx_q   <= hsd_pkg::FIRST_CODE;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= scan_issue;
			if (accept && (cmd == hsd_pkg::CMD_READ)) begin
				issue_ptr_q  <= '0;
				issue_done_q <= 1'b0;
			end else if (scan_issue) begin
				if (issue_ptr_q[hsd_pkg::STEP_W-1:0] == hsd_pkg::LAST_STEP) begin
					issue_ptr_q <= {issue_ptr_q[hsd_pkg::ADDR_W-1:hsd_pkg::STEP_W] + 3'd1,
						hsd_pkg::FIRST_STEP};
					if (issue_ptr_q[hsd_pkg::ADDR_W-1:hsd_pkg::STEP_W] == hsd_pkg::LAST_CODE) begin
						issue_done_q <= 1'b1;
					end
				end else begin
					issue_ptr_q <= issue_ptr_q + 6'd1;
				end
			end
			if (scan_last) begin
				emit_idx_q <= hsd_pkg::FIRST_CODE;
			end else if (emit_fire) begin
				emit_idx_q <= emit_idx_q + 3'd1;
			end
		end
	end

	// Sample address and compare stage datapath.
	always_ff @(posedge clk) begin
		if (ram_ctrl.rd_en && (state_q == hsd_pkg::ST_IDLE)) begin
			sample_addr_q <= {sensor_code, drive_step};
		end
		addr_s1 <= issue_ptr_q;
		if (rd_valid_s1) begin
			best_q <= best_next;
			pick_q <= pick_next;
			if (step_s1 == hsd_pkg::LAST_STEP) begin
				picks_q[code_s1] <= pick_next;
			end
		end
	end

	// Summary of the finished codes for the table check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invalid_q <= '0;
			seen_q    <= '0;
		end else if (accept && (cmd == hsd_pkg::CMD_READ)) begin
			invalid_q <= '0;
			seen_q    <= '0;
		end else if (rd_valid_s1 && (step_s1 == hsd_pkg::LAST_STEP)) begin
			if (pick_next == '0) begin
				invalid_q <= invalid_q + 4'd1;
			end
			seen_q <= seen_q | pick_onehot;
		end
	end

	// Result register: one transfer per cycle during the result phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else begin
			valid <= emit_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			hall_code <= emit_idx_q;
			step_code <= picks_q[emit_idx_q];
			table_ok  <= (invalid_q == hsd_pkg::INVALID_WANTED) && (&seen_q);
			last      <= (emit_idx_q == hsd_pkg::LAST_CODE);
		end
	end

endmodule

@@ rtl/core/hsd_checker.sv @@
// Port-level checks for the hall sequence detector, with the bind that attaches them.
// Depends on hsd_pkg and hall_sequence_detector_top.
module hsd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic [hsd_pkg::CMD_W-1:0]  cmd,
	input logic [hsd_pkg::STEP_W-1:0] drive_step,
	input logic                       valid,
	input logic [hsd_pkg::CODE_W-1:0] hall_code,
	input logic [hsd_pkg::STEP_W-1:0] step_code,
	input logic                       table_ok,
	input logic                       last
);

	// Results of a read come out with consecutive codes.
	a_code_order: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |=> (valid && (hall_code == $past(hall_code) + 3'd1)))
		else $error("result codes out of order");

	// The table flag is the same over all results of a read.
	a_flag_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |=> (table_ok == $past(table_ok)))
		else $error("table flag changed within a read");

	// The final transfer of a read is the one for the highest code.
	a_last_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (last == (hall_code == hsd_pkg::LAST_CODE)))
		else $error("last flag on the wrong result");

	// A reported step is in range.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (step_code <= hsd_pkg::STEP_LIMIT))
		else $error("step code out of range");

	// An accepted sample of a real step keeps the block busy for its write-back.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == hsd_pkg::CMD_SAMPLE) && (drive_step < hsd_pkg::STEP_LIMIT))
		|=> busy)
		else $error("sample not held busy");

endmodule

bind hall_sequence_detector_top hsd_checker u_hsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cmd       (cmd),
	.drive_step(drive_step),
	.valid     (valid),
	.hall_code (hall_code),
	.step_code (step_code),
	.table_ok  (table_ok),
	.last      (last)
);

@@ tb/sv/tb_hall_sequence_detector_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for hall_sequence_detector_top: directed tests, then random rotations.
// Depends on hsd_pkg and the detector RTL; a local tally of sample counts predicts every read.
module tb_hall_sequence_detector_top;
	import hsd_pkg::*;

	// Narrow counters let saturation be reached within a short run.
	localparam int unsigned COUNT_W = 4;
	localparam logic [COUNT_W-1:0] TALLY_MAX = '1;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned NUM_CODES = 8;
	localparam int unsigned NUM_STEPS = 6;
	localparam int unsigned RESET_CYCLES = 10;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned QUIET_LIMIT = 1000;
	localparam int unsigned RANDOM_ITEMS = 85;

	typedef struct packed {
		logic [CODE_W-1:0] hall_code;
		logic [STEP_W-1:0] step_code;
		logic              table_ok;
		logic              last;
	} step_report_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [CMD_W-1:0]    cmd = CMD_SAMPLE;
	logic [CODE_W-1:0]   sensor_code = '0;
	logic [STEP_W-1:0]   drive_step = '0;
	logic                min_samples_we = 1'b0;
	logic [MIN_W-1:0]    min_samples = MIN_SAMPLES_RST;
	logic                valid;
	logic [CODE_W-1:0]   hall_code;
	logic [STEP_W-1:0]   step_code;
	logic                table_ok;
	logic                last;

	// Predicted detector state and the reads still waiting for their results.
	logic [COUNT_W-1:0]  hall_tally [NUM_CODES][NUM_STEPS];
	logic [MIN_W-1:0]    tally_floor;
	logic [CODE_W-1:0]   hall_layout [NUM_STEPS];
	step_report_t        expected_steps [$];

	int unsigned idle_pct = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatch_count = 0;
	int unsigned commands_sent = 0;
	int unsigned reads_sent = 0;
	int unsigned tables_found = 0;
	int unsigned results_checked = 0;

	hall_sequence_detector_top #(
		.COUNT_WIDTH(COUNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.sensor_code(sensor_code),
		.drive_step(drive_step),
		.min_samples_we(min_samples_we),
		.min_samples(min_samples),
		.valid(valid),
		.hall_code(hall_code),
		.step_code(step_code),
		.table_ok(table_ok),
		.last(last)
	);

	always #2 clk = ~clk;

	// Step with the largest count for a code, lowest step on a tie, plus one; zero if none.
	function automatic logic [STEP_W-1:0] best_step(input int code);
		logic [COUNT_W-1:0] top_count;
		logic [STEP_W-1:0]  pick;
		top_count = '0;
		pick = '0;
		for (int s = 0; s < NUM_STEPS; s++) begin
			if (hall_tally[code][s] > top_count) begin
				top_count = hall_tally[code][s];
				if (MIN_W'(hall_tally[code][s]) > tally_floor)
					pick = STEP_W'(s + 1);
			end
		end
		return pick;
	endfunction

	task automatic clear_tally();
		for (int h = 0; h < NUM_CODES; h++)
			for (int s = 0; s < NUM_STEPS; s++)
				hall_tally[h][s] = '0;
	endtask

	// Update the predicted counters for one accepted command and queue any read results.
	task automatic apply_command(input logic [CMD_W-1:0] c, input logic [CODE_W-1:0] code,
			input logic [STEP_W-1:0] step);
		logic [STEP_W-1:0]    picks [NUM_CODES];
		logic [NUM_STEPS-1:0] covered;
		int unsigned          invalid_codes;
		logic                 complete;
		step_report_t         report;
		case (c)
			CMD_SAMPLE: begin
				if (step < STEP_LIMIT && hall_tally[code][step] != TALLY_MAX)
					hall_tally[code][step] = hall_tally[code][step] + 1'b1;
			end
			CMD_CLEAR: begin
				clear_tally();
			end
			CMD_READ: begin
				covered = '0;
				invalid_codes = 0;
				for (int h = 0; h < NUM_CODES; h++) begin
					picks[h] = best_step(h);
					if (picks[h] == '0)
						invalid_codes++;
					else
						covered[picks[h] - 1'b1] = 1'b1;
				end
				complete = (invalid_codes == INVALID_WANTED) && (&covered);
				reads_sent++;
				if (complete)
					tables_found++;
				for (int h = 0; h < NUM_CODES; h++) begin
					report.hall_code = CODE_W'(h);
					report.step_code = picks[h];
					report.table_ok = complete;
					report.last = (h == LAST_CODE);
					expected_steps.push_back(report);
				end
			end
			default: begin
			end
		endcase
	endtask

	// Drive one command and hold it until the transfer; then maybe leave the port idle.
	task automatic send_command(input logic [CMD_W-1:0] c, input logic [CODE_W-1:0] code,
			input logic [STEP_W-1:0] step);
		int unsigned gap;
		start <= 1'b1;
		cmd <= c;
		sensor_code <= code;
		drive_step <= step;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_command(c, code, step);
		commands_sent++;
		@(negedge clk);
		gap = 0;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(8, 1);
			if ($urandom_range(9) == 0)
				gap = $urandom_range(64, 9);
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Register writes happen only once the block has drained and settled.
	task automatic write_min_samples(input logic [MIN_W-1:0] value);
		start <= 1'b0;
		while (expected_steps.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		min_samples_we <= 1'b1;
		min_samples <= value;
		@(negedge clk);
		min_samples_we <= 1'b0;
		tally_floor = value;
	endtask

	// Random assignment of six distinct sensor codes to the six steps.
	task automatic shuffle_hall_layout();
		int unsigned order [NUM_CODES];
		int unsigned j;
		int unsigned held;
		for (int i = 0; i < NUM_CODES; i++)
			order[i] = i;
		for (int i = NUM_CODES - 1; i > 0; i--) begin
			j = $urandom_range(i);
			held = order[i];
			order[i] = order[j];
			order[j] = held;
		end
		for (int s = 0; s < NUM_STEPS; s++)
			hall_layout[s] = CODE_W'(order[s]);
	endtask

	task automatic check_field(input string field, input logic [CODE_W-1:0] code,
			input logic [2:0] want, input logic [2:0] got);
		if (got !== want) begin
			$display("%0t: %s for code %0d expected %0d actual %0d",
				$time, field, code, want, got);
			mismatch_count++;
		end
	endtask

	// Every result strobe is one transfer; compare it with the oldest prediction.
	always @(posedge clk) begin
		step_report_t want;
		if (arst_n && valid) begin
			if (expected_steps.size() == 0) begin
				$display("%0t: result for code %0d arrived with no read outstanding",
					$time, hall_code);
				mismatch_count++;
			end else begin
				want = expected_steps.pop_front();
				check_field("hall_code", want.hall_code, want.hall_code, hall_code);
				check_field("step_code", want.hall_code, want.step_code, step_code);
				check_field("table_ok", want.hall_code, want.table_ok, table_ok);
				check_field("last", want.hall_code, want.last, last);
				results_checked++;
			end
		end
	end

	// Watchdog: too long without any transfer or register write ends the run.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid || min_samples_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results still expected",
				$time, QUIET_LIMIT, expected_steps.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Unused command and out-of-range steps must leave the counters alone and give no result.
	task automatic test_ignored_commands();
		idle_pct = 30;
		send_command(CMD_UNUSED, LAST_CODE, LAST_STEP);
		send_command(CMD_SAMPLE, FIRST_CODE, STEP_LIMIT);
		send_command(CMD_SAMPLE, FIRST_CODE, '1);
		send_command(CMD_READ, FIRST_CODE, FIRST_STEP);
	endtask

	// A threshold of zero, one sample per step, a tie, and codes never sampled.
	task automatic test_full_table();
		write_min_samples('0);
		idle_pct = 30;
		send_command(CMD_CLEAR, '1, '1);
		for (int s = 0; s < NUM_STEPS; s++)
			send_command(CMD_SAMPLE, CODE_W'(s + 1), STEP_W'(s));
		// Code 1 now ties between steps 0 and 4; the lower step must win.
		send_command(CMD_SAMPLE, CODE_W'(1), STEP_W'(4));
		send_command(CMD_READ, '0, '0);
	endtask

	// Push one counter past its maximum; a wrapped count would lose the step.
	task automatic test_saturation();
		idle_pct = 30;
		repeat (TALLY_MAX) send_command(CMD_SAMPLE, CODE_W'(6), LAST_STEP);
		write_min_samples(MIN_W'(TALLY_MAX - 1'b1));
		idle_pct = 30;
		send_command(CMD_READ, LAST_CODE, FIRST_STEP);
	endtask

	// Mostly well-formed rotations through a random code layout, with reads,
	// clears and random noise mixed in.
	task automatic test_random_rotation(input int unsigned pct, input logic [MIN_W-1:0] floor_value);
		int unsigned      placed;
		int unsigned      roll;
		int               step_now;
		int               direction;
		logic [CMD_W-1:0] noise_cmd;
		logic [STEP_W-1:0] noise_step;
		write_min_samples(floor_value);
		idle_pct = pct;
		shuffle_hall_layout();
		placed = 0;
		step_now = $urandom_range(NUM_STEPS - 1);
		direction = $urandom_range(1) ? 1 : -1;
		while (placed < RANDOM_ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 4) begin
				send_command(CMD_READ, CODE_W'($urandom), STEP_W'($urandom));
				placed++;
			end else if (roll < 6) begin
				send_command(CMD_CLEAR, CODE_W'($urandom), STEP_W'($urandom));
				shuffle_hall_layout();
				placed++;
			end else if (roll < 12) begin
				noise_cmd = CMD_W'($urandom_range(3));
				noise_step = STEP_W'($urandom_range(7));
				send_command(noise_cmd, CODE_W'($urandom_range(7)), noise_step);
				if (noise_cmd == CMD_READ || noise_cmd == CMD_CLEAR ||
						(noise_cmd == CMD_SAMPLE && noise_step < STEP_LIMIT))
					placed++;
			end else begin
				// Occasionally reverse or sample the same step twice.
				if (roll < 14)
					direction = -direction;
				else if (roll >= 16)
					step_now = (step_now + direction + NUM_STEPS) % NUM_STEPS;
				send_command(CMD_SAMPLE, hall_layout[step_now], STEP_W'(step_now));
				placed++;
			end
		end
	endtask

	initial begin
		clear_tally();
		tally_floor = MIN_SAMPLES_RST;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_ignored_commands();
		test_full_table();
		test_saturation();
		test_random_rotation(0, '0);
		test_random_rotation(59, '1);
		test_random_rotation(0, MIN_W'($urandom_range(16, 1)));
		test_random_rotation(8, MIN_SAMPLES_RST);

		start <= 1'b0;
		while (expected_steps.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Sent %0d commands including %0d reads; checked %0d results.",
			commands_sent, reads_sent, results_checked);
		$display("%0d reads found a complete six-step table; %0d mismatches.",
			tables_found, mismatch_count);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
